FILE: rtl/core/swmf_pkg.sv
// ----------------------------------------------------------------------------
// swmf_pkg: shared types and constants for the sliding window mode filter
// widths of samples, counts and tree node indexes, plus the
// request and status records between the sequencer and the tree unit
// ----------------------------------------------------------------------------
package swmf_pkg;

  // histogram range and window depth, both powers of two
  localparam int NUM_VALUES = 256;
  localparam int WINDOW_MAX = 256;

  localparam int VAL_W  = $clog2(NUM_VALUES);      // sample / value width
  localparam int NODE_W = VAL_W + 1;               // tree node index width
  localparam int POS_W  = $clog2(WINDOW_MAX);      // ring slot index width
  localparam int CNT_W  = $clog2(WINDOW_MAX + 1);  // count up to WINDOW_MAX
  localparam int WL_W   = 9;                       // window_length register

  // one tree entry: the winning count and its value
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [VAL_W-1:0] value;
  } node_t;

  // sequencer to tree unit
  typedef struct packed {
    logic             start;
    logic             up;
    logic [VAL_W-1:0] leaf;
  } tree_req_t;

  // tree unit to sequencer
  typedef struct packed {
    logic             ready;
    logic             done;
    logic [VAL_W-1:0] root;
  } tree_sts_t;

endpackage

FILE: rtl/core/swmf_tree.sv
// ----------------------------------------------------------------------------
// swmf_tree: histogram max-tree with a shared compare unit
// one leaf read-modify-write, then one parent update per level,
// walking from leaf to root through a single tree memory
// ----------------------------------------------------------------------------
module swmf_tree
  import swmf_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  tree_req_t req,
  output tree_sts_t sts
);

  typedef enum logic [1:0] {T_CLEAR, T_IDLE, T_LEAF, T_LEVEL} tstate_t;

  localparam int NODES = 2 * NUM_VALUES;

  node_t              mem [NODES];
  node_t              rd_data;
  logic [NODE_W-1:0]  rd_addr;
  logic               wr_en;
  logic [NODE_W-1:0]  wr_addr;
  node_t              wr_data;

  tstate_t            state;
  logic [NODE_W-1:0]  clr_idx;
  logic [NODE_W-1:0]  node_idx;
  logic [NODE_W-1:0]  parent_idx;
  logic               up_r;
  node_t              cur;
  node_t              leaf_new;
  node_t              parent;
  logic               done;
  logic [VAL_W-1:0]   root;

  // leftmost leaf under a node: its value after reset
  function automatic logic [VAL_W-1:0] first_leaf(input logic [NODE_W-1:0] idx);
    logic [NODE_W-1:0] t;
    t = idx;
    for (int k = 0; k < NODE_W - 1; k++) begin
      if (!t[NODE_W-1]) t = t << 1;
    end
    return t[VAL_W-1:0];
  endfunction

  // larger count wins, smaller value on equal counts
  function automatic node_t pick(input node_t a, input node_t b);
    if (a.count > b.count) return a;
    if (a.count < b.count) return b;
    return (b.value < a.value) ? b : a;
  endfunction

  assign parent_idx = node_idx >> 1;

  always_comb begin
    if (up_r) begin
      leaf_new.count = rd_data.count + CNT_W'(1);
    end else if (rd_data.count != '0) begin
      leaf_new.count = rd_data.count - CNT_W'(1);
    end else begin
      leaf_new.count = '0;
    end
    leaf_new.value = rd_data.value;
    parent = node_idx[0] ? pick(rd_data, cur) : pick(cur, rd_data);
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = node_idx;
    wr_data = cur;
    rd_addr = node_idx;
    case (state)
      T_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_idx;
        wr_data = '{count: '0, value: first_leaf(clr_idx)};
      end
      T_IDLE: begin
        rd_addr = {1'b1, req.leaf};
      end
      T_LEAF: begin
        wr_en   = 1'b1;
        wr_data = leaf_new;
        rd_addr = node_idx ^ NODE_W'(1);
      end
      T_LEVEL: begin
        wr_en   = 1'b1;
        wr_addr = parent_idx;
        wr_data = parent;
        rd_addr = parent_idx ^ NODE_W'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= T_CLEAR;
      clr_idx <= '0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        T_CLEAR: begin
          clr_idx <= clr_idx + NODE_W'(1);
          if (clr_idx == NODE_W'(NODES - 1)) state <= T_IDLE;
        end
        T_IDLE: begin
          if (req.start) begin
            node_idx <= {1'b1, req.leaf};
            up_r     <= req.up;
            state    <= T_LEAF;
          end
        end
        T_LEAF: begin
          cur   <= leaf_new;
          state <= T_LEVEL;
        end
        T_LEVEL: begin
          cur      <= parent;
          node_idx <= parent_idx;
          if (parent_idx == NODE_W'(1)) begin
            root  <= parent.value;
            done  <= 1'b1;
            state <= T_IDLE;
          end
        end
        default: state <= T_IDLE;
      endcase
    end
  end

  assign sts.ready = (state == T_IDLE);
  assign sts.done  = done;
  assign sts.root  = root;

endmodule

FILE: rtl/core/sliding_window_mode_filter.sv
// ----------------------------------------------------------------------------
// sliding_window_mode_filter: running mode over the last window_length samples
// keeps the window in a ring memory and per-value counts in a max-tree;
// emits the window mode, smallest value on ties, once the window is full
// ----------------------------------------------------------------------------
// sequencing: a sample word is taken only in idle, so the next one waits until the
//   leaf-to-root walks of the tree unit for the count up and any retirements
//   are done, plus sequencing; a held output word stalls the emit
// reset: synchronous; the tree memory is cleared after reset,
//   s_tready stays low meanwhile, configuration writes are taken at any time
// ----------------------------------------------------------------------------
module sliding_window_mode_filter
  import swmf_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  // configuration: window_length
  input  logic            cfg_we,
  input  logic [WL_W-1:0] cfg_wdata,
  // sample stream
  input  logic            s_tvalid,
  output logic            s_tready,
  input  logic [7:0]      s_tdata,   // [7:0] sample
  // mode stream
  output logic            m_tvalid,
  input  logic            m_tready,
  output logic [7:0]      m_tdata    // [7:0] mode_value
);

  typedef enum logic [2:0] {
    S_IDLE, S_WAIT_UP, S_EMIT, S_RETIRE_RD, S_RETIRE_ST, S_WAIT_DN
  } state_t;

  state_t           state;
  logic [WL_W-1:0]  window_length;
  logic [CNT_W-1:0] win_eff;
  logic [POS_W-1:0] ring_position;
  logic [CNT_W-1:0] samples_seen;
  logic [VAL_W-1:0] ring [WINDOW_MAX];
  logic [VAL_W-1:0] ring_q;
  logic [POS_W-1:0] oldest;
  logic [VAL_W-1:0] mode_value;
  logic             s_accept;
  logic             window_full;
  tree_req_t        tree_req;
  tree_sts_t        tree_sts;

  // window length zero acts as one, above the ring depth it saturates
  always_comb begin
    if (window_length == '0) begin
      win_eff = CNT_W'(1);
    end else if (window_length > WL_W'(WINDOW_MAX)) begin
      win_eff = CNT_W'(WINDOW_MAX);
    end else begin
      win_eff = CNT_W'(window_length);
    end
  end

  assign window_full = (samples_seen >= win_eff);

  // oldest held sample sits samples_seen slots behind the write slot
  assign oldest = ring_position - samples_seen[POS_W-1:0];

  // sample width equals the histogram range, so no value saturation is needed
  assign s_tready = (state == S_IDLE) && tree_sts.ready;
  assign s_accept = s_tvalid && s_tready;

  // count up on a new sample, count down when retiring the oldest one
  assign tree_req.start = s_accept || (state == S_RETIRE_ST);
  assign tree_req.up    = (state == S_IDLE);
  assign tree_req.leaf  = (state == S_IDLE) ? s_tdata[VAL_W-1:0] : ring_q;

  swmf_tree u_tree (
    .clk (clk),
    .rst (rst),
    .req (tree_req),
    .sts (tree_sts)
  );

  // window ring: written on accept, read when retiring
  always_ff @(posedge clk) begin
    if (s_accept) ring[ring_position] <= s_tdata[VAL_W-1:0];
    ring_q <= ring[oldest];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= WL_W'(1);
    end else if (cfg_we) begin
      window_length <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      ring_position <= '0;
      samples_seen  <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      // output word leaves when taken; the emit state reloads it itself
      if (m_tvalid && m_tready && (state != S_EMIT)) m_tvalid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (s_accept) begin
            ring_position <= ring_position + POS_W'(1);
            samples_seen  <= samples_seen + CNT_W'(1);
            state         <= S_WAIT_UP;
          end
        end
        S_WAIT_UP: begin
          if (tree_sts.done) state <= window_full ? S_EMIT : S_IDLE;
        end
        S_EMIT: begin
          // root of the tree is the mode; wait for the output register
          if (!m_tvalid || m_tready) begin
            m_tvalid   <= 1'b1;
            mode_value <= tree_sts.root;
            state      <= S_RETIRE_RD;
          end
        end
        S_RETIRE_RD: begin
          // retire until win_eff - 1 samples remain
          state <= window_full ? S_RETIRE_ST : S_IDLE;
        end
        S_RETIRE_ST: begin
          samples_seen <= samples_seen - CNT_W'(1);
          state        <= S_WAIT_DN;
        end
        S_WAIT_DN: begin
          if (tree_sts.done) state <= S_RETIRE_RD;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_tdata = 8'(mode_value);

  // window never holds more than the ring depth
  a_seen_bound: assert property (@(posedge clk) disable iff (rst)
    samples_seen <= CNT_W'(WINDOW_MAX))
    else $error("samples_seen above ring depth");

  // a tree walk starts only when the tree unit is free
  a_start_ready: assert property (@(posedge clk) disable iff (rst)
    tree_req.start |-> tree_sts.ready)
    else $error("tree walk started while busy");

  // the tree unit is busy right after a walk starts
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    tree_req.start |=> !tree_sts.ready)
    else $error("tree unit did not take the walk");

  // walk completion only while the sequencer waits for it
  a_done_wait: assert property (@(posedge clk) disable iff (rst)
    tree_sts.done |-> (state == S_WAIT_UP || state == S_WAIT_DN))
    else $error("tree walk done outside a wait state");

  // a result is loaded only when the window was full after the count up
  a_emit_full: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |-> window_full)
    else $error("result with window not full");

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for sliding_window_mode_filter
// drives sample words with random gaps and back-pressure, predicts the
// window mode from a plain histogram and checks every mode word in order
// ----------------------------------------------------------------------------
module testbench
  import swmf_pkg::*;
();

  // bench timing
  localparam int RST_CYCLES  = 5;
  localparam int IDLE_PCT    = 16;
  localparam int RANDOM_ITEMS = 500;
  // rough per-sample cost after the last mode word, plus per extra retirement
  localparam int SETTLE_BASE   = 64;
  localparam int SETTLE_RETIRE = 16;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_we = 1'b0;
  logic [WL_W-1:0]  cfg_wdata = '0;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [7:0]       s_tdata = '0;   // [7:0] sample
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [7:0]       m_tdata;        // [7:0] mode_value

  sliding_window_mode_filter uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // predictor state: window contents, per-value histogram and the register
  logic [7:0]      held_ring [WINDOW_MAX];
  int              hist [NUM_VALUES];
  int              ring_wr;
  int              held_count;
  int              last_retired;
  logic [WL_W-1:0] window_reg;

  logic [7:0] mode_q [$];   // expected mode words, oldest first
  int         errors;
  int         sent_items;
  bit         idle_on;

  // window length as the block uses it: zero acts as one, saturate at depth
  function automatic int eff_window();
    if (window_reg == 0) return 1;
    if (window_reg > WINDOW_MAX) return WINDOW_MAX;
    return window_reg;
  endfunction

  // account for one accepted sample and queue the mode it produces, if any
  function automatic void take_sample(input logic [7:0] s);
    int w;
    int best;
    int oldest;
    w = eff_window();
    held_ring[ring_wr] = s;
    ring_wr = (ring_wr + 1) % WINDOW_MAX;
    held_count++;
    hist[s]++;
    last_retired = 0;
    if (held_count >= w) begin
      // largest count wins, smallest value on ties
      best = 0;
      for (int v = 1; v < NUM_VALUES; v++) begin
        if (hist[v] > hist[best]) best = v;
      end
      mode_q.insert(mode_q.size(), best[7:0]);
      // retire oldest samples; a shrunk window retires several at once
      while (held_count > w - 1) begin
        oldest = (ring_wr + WINDOW_MAX - held_count) % WINDOW_MAX;
        if (hist[held_ring[oldest]] > 0) hist[held_ring[oldest]]--;
        held_count--;
        last_retired++;
      end
    end
  endfunction

  // result side: random back-pressure, checked against the oldest expectation
  always @(negedge clk) begin
    m_tready <= !idle_on || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (mode_q.size() == 0) begin
        $error("mode_value: no word expected, actual %0d", m_tdata);
        errors++;
      end else begin
        if (m_tdata !== mode_q[0]) begin
          $error("mode_value: expected %0d, actual %0d", mode_q[0], m_tdata);
          errors++;
        end
        void'(mode_q.pop_front());
      end
    end
  end

  // send one sample word; entered and left at a falling edge, tvalid left high
  task automatic send_sample(input logic [7:0] s);
    while (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= s;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    take_sample(s);
    sent_items++;
    @(negedge clk);
  endtask

  // hold off the sender until every mode word is back and the block settles
  task automatic wait_for_idle();
    s_tvalid <= 1'b0;
    wait (mode_q.size() == 0);
    @(negedge clk);
    repeat (SETTLE_BASE + SETTLE_RETIRE * last_retired) @(negedge clk);
  endtask

  task automatic set_window(input logic [WL_W-1:0] v);
    wait_for_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    window_reg = v;
  endtask

  // mostly clustered values so modes and ties are frequent, some full range
  task automatic send_burst(input int n, input logic [7:0] base, input int spread);
    logic [7:0] s;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 70) s = base + 8'($urandom_range(0, spread));
      else s = 8'($urandom_range(0, 255));
      send_sample(s);
    end
  endtask

  // reset window of one: each sample is its own mode, field extremes
  task automatic test_unit_window();
    send_sample(8'h00);
    send_sample(8'hFF);
    send_sample(8'hAA);
    send_sample(8'h55);
  endtask

  // equal counts resolve to the smaller value
  task automatic test_tie_break();
    set_window(WL_W'(4));
    send_sample(8'd9);
    send_sample(8'd3);
    send_sample(8'd9);
    send_sample(8'd3);
    send_sample(8'd200);
  endtask

  // zero length behaves as one
  task automatic test_zero_window();
    set_window('0);
    send_sample(8'd77);
    send_sample(8'd78);
  endtask

  // fill a wide window, then shrink it so one word retires many samples
  task automatic test_shrink();
    set_window(WL_W'(8));
    send_sample(8'd40);
    send_sample(8'd41);
    send_sample(8'd41);
    send_sample(8'd40);
    send_sample(8'd42);
    send_sample(8'd40);
    send_sample(8'd41);
    send_sample(8'd43);
    set_window(WL_W'(2));
    send_sample(8'd41);
    send_sample(8'd40);
  endtask

  // growing the window holds results back until it fills again
  task automatic test_grow();
    set_window(WL_W'(5));
    send_sample(8'd7);
    send_sample(8'd8);
    send_sample(8'd8);
    send_sample(8'd6);
  endtask

  // all-ones register saturates to full depth; no idling on either side in its burst
  task automatic test_full_depth();
    idle_on = 1'b0;
    set_window('1);
    send_burst(264, 8'($urandom_range(0, 255)), 5);
    idle_on = 1'b1;
    // exact full depth keeps the window as is
    set_window(WL_W'(WINDOW_MAX));
    send_burst(12, 8'($urandom_range(0, 255)), 3);
    // just above full depth also saturates
    set_window(WL_W'(WINDOW_MAX + 1));
    send_burst(6, 8'($urandom_range(0, 255)), 3);
    // collapse to one in a single word
    set_window(WL_W'(1));
    send_burst(4, 8'h00, 255);
  endtask

  // random window lengths and clustered sample streams
  task automatic test_random_windows();
    int         pick;
    int         len;
    bit         paused;
    logic [7:0] base;
    paused = 1'b0;
    while (sent_items < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) set_window(WL_W'($urandom_range(1, 24)));
      else if (pick < 90) set_window('0);
      else set_window(WL_W'($urandom_range(25, 64)));
      len  = $urandom_range(10, 40);
      base = 8'($urandom_range(0, 255));
      send_burst(len / 2, base, $urandom_range(0, 7));
      if (!paused) begin
        // sender holds off mid-stream until the output side catches up
        wait_for_idle();
        paused = 1'b1;
      end
      send_burst(len - len / 2, base, $urandom_range(0, 7));
    end
  endtask

  initial begin
    for (int i = 0; i < NUM_VALUES; i++) hist[i] = 0;
    for (int i = 0; i < WINDOW_MAX; i++) held_ring[i] = '0;
    ring_wr      = 0;
    held_count   = 0;
    last_retired = 0;
    window_reg   = WL_W'(1);
    errors       = 0;
    sent_items   = 0;
    idle_on      = 1'b1;

    repeat (RST_CYCLES) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_unit_window();
    test_tie_break();
    test_zero_window();
    test_shrink();
    test_grow();
    test_full_depth();
    test_random_windows();

    wait_for_idle();
    if (errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  // run limit
  initial begin
    #10_000_000;
    $display("testbench: FAIL");
    $finish;
  end

endmodule
